@@ design/cmej_pkg.sv @@
// ----------------------------------------------------------------------------
// cmej_pkg: shared types and constants for the cluster move energy judge
// Widths of the cluster store, the face fields and the energy arithmetic.
// ----------------------------------------------------------------------------
package cmej_pkg;

  localparam int MaxClusters = 256;
  localparam int ClW         = $clog2(MaxClusters);
  localparam int CntW        = 9;
  localparam int LimW        = (CntW > ClW + 1) ? CntW : ClW + 1;
  localparam int SrcW        = 9;
  localparam int TgtW        = 8;
  localparam int FaceW       = 24;
  localparam int CoordW      = 32;
  localparam int AreaW       = 40;
  localparam int SumW        = 48;
  localparam int HalfW       = SumW / 2;
  localparam int NumW        = 96;
  localparam int QsumW       = NumW + 1;
  localparam int StepW       = $clog2(NumW);

  localparam logic [SrcW-1:0] FreeSrc  = '1;
  localparam logic [CntW-1:0] CntReset = CntW'(256);

  // One cluster entry: accumulated area and weighted centroid sums
  typedef struct packed {
    logic [AreaW-1:0] area;
    logic [SumW-1:0]  sx;
    logic [SumW-1:0]  sy;
    logic [SumW-1:0]  sz;
  } entry_t;

endpackage

@@ design/cmej_if.sv @@
// ----------------------------------------------------------------------------
// cmej_if: valid/ready channel interfaces of the cluster move energy judge
// Face input, decision output and cluster count configuration channels.
// ----------------------------------------------------------------------------
interface cmej_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [cmej_pkg::SrcW-1:0]   source_cluster;
  logic        [cmej_pkg::TgtW-1:0]   target_cluster;
  logic        [cmej_pkg::FaceW-1:0]  face_area;
  logic signed [cmej_pkg::CoordW-1:0] weighted_x;
  logic signed [cmej_pkg::CoordW-1:0] weighted_y;
  logic signed [cmej_pkg::CoordW-1:0] weighted_z;
  modport source (output valid, source_cluster, target_cluster, face_area,
                  weighted_x, weighted_y, weighted_z, input ready);
  modport sink   (input valid, source_cluster, target_cluster, face_area,
                  weighted_x, weighted_y, weighted_z, output ready);
endinterface

interface cmej_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic bad_cluster;
  modport source (output valid, accepted, bad_cluster, input ready);
  modport sink   (input valid, accepted, bad_cluster, output ready);
endinterface

interface cmej_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cmej_pkg::CntW-1:0]    cluster_count;
  modport source (output valid, cluster_count, input ready);
  modport sink   (input valid, cluster_count, output ready);
endinterface

@@ design/cmej_store.sv @@
// ----------------------------------------------------------------------------
// cmej_store: cluster entry memory
// One write port, two registered read ports; per-entry valid bits make
// never-written entries read as zero.
// ----------------------------------------------------------------------------
module cmej_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [cmej_pkg::ClW-1:0]       rd_a_addr_i,
  input  logic [cmej_pkg::ClW-1:0]       rd_b_addr_i,
  output cmej_pkg::entry_t               rd_a_o,
  output cmej_pkg::entry_t               rd_b_o,
  input  logic                           wr_en_i,
  input  logic [cmej_pkg::ClW-1:0]       wr_addr_i,
  input  cmej_pkg::entry_t               wr_data_i
);

  cmej_pkg::entry_t                        mem [cmej_pkg::MaxClusters];
  logic [cmej_pkg::MaxClusters-1:0]        valid_q;
  cmej_pkg::entry_t                        rd_a_q, rd_b_q;
  logic                                    rd_a_vld_q, rd_b_vld_q;

  // Write the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_a_vld_q <= valid_q[rd_a_addr_i];
        rd_b_vld_q <= valid_q[rd_b_addr_i];
      end
    end
  end

  // Register read data, hold until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem[rd_a_addr_i];
      rd_b_q <= mem[rd_b_addr_i];
    end
  end

  assign rd_a_o = rd_a_vld_q ? rd_a_q : '0;
  assign rd_b_o = rd_b_vld_q ? rd_b_q : '0;

endmodule

@@ design/cmej_term.sv @@
// ----------------------------------------------------------------------------
// cmej_term: iterative energy term unit
// Computes (sx^2 + sy^2 + sz^2) / area, truncated, with one shared 24x24
// multiplier (a multiply and an accumulate step per partial product) and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmej_term (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cmej_pkg::SumW-1:0]     sx_i,
  input  logic [cmej_pkg::SumW-1:0]     sy_i,
  input  logic [cmej_pkg::SumW-1:0]     sz_i,
  input  logic [cmej_pkg::AreaW-1:0]    area_i,
  output logic                          done_o,
  output logic [cmej_pkg::NumW-1:0]     quot_o
);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_MUL  = 4'b0010,
    T_ACC  = 4'b0100,
    T_DIV  = 4'b1000
  } tstate_e;

  localparam int HW = cmej_pkg::HalfW;
  localparam int SW = cmej_pkg::SumW;
  localparam int NW = cmej_pkg::NumW;
  localparam int AW = cmej_pkg::AreaW;

  tstate_e                       state_q, state_d;
  logic [SW-1:0]                 mx_q, my_q, mz_q;
  logic [AW-1:0]                 area_q;
  logic [1:0]                    coord_q, part_q;
  logic [SW-1:0]                 prod_q;
  logic [NW-1:0]                 acc_q;
  logic [AW-1:0]                 rem_q;
  logic [cmej_pkg::StepW-1:0]    step_q;
  logic                          done_q;

  logic [SW-1:0]                 mag_sel;
  logic [HW-1:0]                 op_a, op_b;
  logic [NW-1:0]                 addend;
  logic [AW:0]                   shifted;
  logic                          ge;

  function automatic logic [SW-1:0] mag(input logic [SW-1:0] v);
    mag = v[SW-1] ? (~v + SW'(1)) : v;
  endfunction

  // Pick the coordinate and the half-words of this partial product
  always_comb begin
    unique case (coord_q)
      2'd0:    mag_sel = mx_q;
      2'd1:    mag_sel = my_q;
      default: mag_sel = mz_q;
    endcase
    op_a = (part_q == 2'd0) ? mag_sel[HW-1:0] : mag_sel[SW-1:HW];
    op_b = (part_q == 2'd2) ? mag_sel[SW-1:HW] : mag_sel[HW-1:0];
    unique case (part_q)
      2'd0:    addend = NW'(prod_q);
      2'd1:    addend = NW'(prod_q) << (HW + 1);
      default: addend = NW'(prod_q) << SW;
    endcase
  end

  // One restoring division step
  assign shifted = {rem_q, acc_q[NW-1]};
  assign ge      = (shifted >= {1'b0, area_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (start_i) state_d = T_MUL;
      T_MUL:   state_d = T_ACC;
      T_ACC:   state_d = (part_q == 2'd2 && coord_q == 2'd2) ? T_DIV : T_MUL;
      T_DIV:   if (step_q == cmej_pkg::StepW'(NW - 1)) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
      coord_q <= '0;
      part_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == T_DIV) && (state_d == T_IDLE);
      unique case (state_q)
        T_IDLE: begin
          coord_q <= '0;
          part_q  <= '0;
          step_q  <= '0;
        end
        T_ACC: begin
          if (part_q == 2'd2) begin
            part_q  <= '0;
            coord_q <= coord_q + 2'd1;
          end else begin
            part_q <= part_q + 2'd1;
          end
        end
        T_DIV:   step_q <= step_q + cmej_pkg::StepW'(1);
        default: ;
      endcase
    end
  end

  // Datapath: operands, product, accumulator and remainder
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      T_IDLE: begin
        if (start_i) begin
          mx_q   <= mag(sx_i);
          my_q   <= mag(sy_i);
          mz_q   <= mag(sz_i);
          area_q <= area_i;
          acc_q  <= '0;
          rem_q  <= '0;
        end
      end
      T_MUL:   prod_q <= op_a * op_b;
      T_ACC:   acc_q <= acc_q + addend;
      T_DIV: begin
        rem_q <= ge ? AW'(shifted - {1'b0, area_q}) : shifted[AW-1:0];
        acc_q <= {acc_q[NW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

@@ design/cluster_move_energy_judge.sv @@
// ----------------------------------------------------------------------------
// cluster_move_energy_judge: face move decision on cluster energies
// Keeps per-cluster area and weighted centroid sums, adds free faces and
// applies a move only if the summed |W|^2/A of both clusters strictly grows.
// ----------------------------------------------------------------------------
//   channel  dir  transaction
//   cfg_i    in   cluster_count write
//   in_i     in   one face: source, target, area, weighted x/y/z
//   out_o    out  accepted, bad_cluster (one per face)
//
// A rejected out-of-range face goes straight to the result, a free face
// passes the check and one write, and a checked move runs four energy terms,
// each on the shared multiplier and then on the bit-serial divider.
// Reset empties every cluster at once (valid bits) and sets the count to 256.
// in_i is ready only while idle; a pending result holds the sequencer until
// out_o takes it.
// ----------------------------------------------------------------------------
module cluster_move_energy_judge (
  input  logic               clk_i,
  input  logic               rst_ni,
  cmej_cfg_if.sink           cfg_i,
  cmej_in_if.sink            in_i,
  cmej_out_if.source         out_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CHECK  = 8'b00000010,
    S_LOAD   = 8'b00000100,
    S_WAIT   = 8'b00001000,
    S_DECIDE = 8'b00010000,
    S_WR_T   = 8'b00100000,
    S_WR_S   = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_e;

  localparam int LW = cmej_pkg::LimW;
  localparam int CW = cmej_pkg::ClW;

  state_e                          state_q, state_d;
  logic [cmej_pkg::CntW-1:0]       count_q;
  logic [LW-1:0]                   limit;
  logic                            free_in, bad_in, in_fire;
  logic [LW-1:0]                   src_ext, tgt_ext;

  logic                            free_q, same_q;
  logic [CW-1:0]                   src_q, tgt_q;
  logic [cmej_pkg::AreaW-1:0]      face_q;
  logic [cmej_pkg::SumW-1:0]       cx_q, cy_q, cz_q;
  logic [1:0]                      idx_q;
  logic [cmej_pkg::QsumW-1:0]      before_q, after_q;
  logic                            res_acc_q, res_bad_q;
  logic                            out_valid_q, out_acc_q, out_bad_q;

  cmej_pkg::entry_t                rs, rt, new_s, new_t, wr_data;
  logic                            wr_en, term_done;
  logic [CW-1:0]                   wr_addr;
  logic [cmej_pkg::SumW-1:0]       op_x, op_y, op_z;
  logic [cmej_pkg::AreaW-1:0]      op_area;
  logic [cmej_pkg::NumW-1:0]       quot;
  logic                            reject;

  // Range check of the incoming cluster numbers
  assign limit   = (LW'(count_q) < LW'(cmej_pkg::MaxClusters)) ?
                   LW'(count_q) : LW'(cmej_pkg::MaxClusters);
  assign src_ext = LW'(in_i.source_cluster);
  assign tgt_ext = LW'(in_i.target_cluster);
  assign free_in = (in_i.source_cluster == cmej_pkg::FreeSrc);
  assign bad_in  = (tgt_ext >= limit) || (!free_in && src_ext >= limit);
  assign in_fire = in_i.valid && in_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cmej_pkg::CntReset;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.cluster_count;
    end
  end

  cmej_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire),
    .rd_a_addr_i (src_ext[CW-1:0]),
    .rd_b_addr_i (tgt_ext[CW-1:0]),
    .rd_a_o      (rs),
    .rd_b_o      (rt),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data)
  );

  // Updated entries of both clusters
  always_comb begin
    new_t.area = rt.area + face_q;
    new_t.sx   = rt.sx + cx_q;
    new_t.sy   = rt.sy + cy_q;
    new_t.sz   = rt.sz + cz_q;
    new_s.area = rs.area - face_q;
    new_s.sx   = rs.sx - cx_q;
    new_s.sy   = rs.sy - cy_q;
    new_s.sz   = rs.sz - cz_q;
  end

  assign reject  = (rs.area <= face_q) || (rt.area == '0) || (new_t.area == '0);
  assign wr_en   = (state_q == S_WR_T) || (state_q == S_WR_S);
  assign wr_addr = (state_q == S_WR_S) ? src_q : tgt_q;
  assign wr_data = (state_q == S_WR_S) ? new_s : new_t;

  // Term operands: source and target before, then after the move
  always_comb begin
    unique case (idx_q)
      2'd0: begin
        op_x = rs.sx;    op_y = rs.sy;    op_z = rs.sz;    op_area = rs.area;
      end
      2'd1: begin
        op_x = rt.sx;    op_y = rt.sy;    op_z = rt.sz;    op_area = rt.area;
      end
      2'd2: begin
        op_x = new_s.sx; op_y = new_s.sy; op_z = new_s.sz; op_area = new_s.area;
      end
      default: begin
        op_x = new_t.sx; op_y = new_t.sy; op_z = new_t.sz; op_area = new_t.area;
      end
    endcase
  end

  cmej_term u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_LOAD),
    .sx_i    (op_x),
    .sy_i    (op_y),
    .sz_i    (op_z),
    .area_i  (op_area),
    .done_o  (term_done),
    .quot_o  (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire) state_d = bad_in ? S_DONE : S_CHECK;
      S_CHECK: begin
        if (free_q)      state_d = S_WR_T;
        else if (reject) state_d = S_DONE;
        else             state_d = S_LOAD;
      end
      S_LOAD:   state_d = S_WAIT;
      S_WAIT:   if (term_done) state_d = (idx_q == 2'd3) ? S_DECIDE : S_LOAD;
      S_DECIDE: state_d = (after_q > before_q && !same_q) ? S_WR_T : S_DONE;
      S_WR_T:   state_d = free_q ? S_DONE : S_WR_S;
      S_WR_S:   state_d = S_DONE;
      S_DONE:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      res_acc_q   <= 1'b0;
      res_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // Load a finished result, or drop the one just taken
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
        out_acc_q   <= res_acc_q;
        out_bad_q   <= res_bad_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          idx_q     <= '0;
          res_acc_q <= 1'b0;
          res_bad_q <= bad_in;
        end
        S_CHECK:  res_acc_q <= free_q;
        S_WAIT:   if (term_done) idx_q <= idx_q + 2'd1;
        S_DECIDE: res_acc_q <= (after_q > before_q);
        default: ;
      endcase
    end
  end

  // Hold the face and accumulate the energy sums
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      free_q <= free_in;
      same_q <= (src_ext == tgt_ext);
      src_q  <= src_ext[CW-1:0];
      tgt_q  <= tgt_ext[CW-1:0];
      face_q <= cmej_pkg::AreaW'(in_i.face_area);
      cx_q   <= cmej_pkg::SumW'(in_i.weighted_x);
      cy_q   <= cmej_pkg::SumW'(in_i.weighted_y);
      cz_q   <= cmej_pkg::SumW'(in_i.weighted_z);
    end
    if (state_q == S_CHECK) begin
      before_q <= '0;
      after_q  <= '0;
    end else if (state_q == S_WAIT && term_done) begin
      if (idx_q[1]) after_q  <= after_q + cmej_pkg::QsumW'(quot);
      else          before_q <= before_q + cmej_pkg::QsumW'(quot);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.bad_cluster = out_bad_q;

endmodule

@@ verif/tb_cluster_move_energy_judge.sv @@
// ----------------------------------------------------------------------------
// tb_cluster_move_energy_judge: self-checking bench for the move energy judge
// Drives faces through bursty valid/ready traffic and checks every decision
// against an in-bench cluster store model. Starts with a directed table,
// then runs random load and move sequences under several cluster counts.
// ----------------------------------------------------------------------------
module tb_cluster_move_energy_judge;
  timeunit 1ns;
  timeprecision 1ps;

  // Shared widths and constants
  localparam int MaxClusters = cmej_pkg::MaxClusters;
  localparam int CntW        = cmej_pkg::CntW;
  localparam int SrcW        = cmej_pkg::SrcW;
  localparam int TgtW        = cmej_pkg::TgtW;
  localparam int FaceW       = cmej_pkg::FaceW;
  localparam int CoordW      = cmej_pkg::CoordW;
  localparam int AreaW       = cmej_pkg::AreaW;
  localparam int SumW        = cmej_pkg::SumW;
  localparam logic [SrcW-1:0] FreeSrc  = cmej_pkg::FreeSrc;
  localparam logic [CntW-1:0] CntReset = cmej_pkg::CntReset;

  localparam int unsigned CycleLimit = 20_000_000;

  typedef struct packed {
    logic [SrcW-1:0]   src;
    logic [TgtW-1:0]   tgt;
    logic [FaceW-1:0]  area;
    logic [CoordW-1:0] wx;
    logic [CoordW-1:0] wy;
    logic [CoordW-1:0] wz;
  } face_t;

  typedef struct packed {
    logic acc;
    logic bad;
  } verdict_t;

  typedef struct {
    face_t    face;
    logic     known;
    verdict_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cmej_in_if  in_if ();
  cmej_out_if out_if ();
  cmej_cfg_if cfg_if ();

  cluster_move_energy_judge u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Model of the cluster store and the count register
  logic [AreaW-1:0] mdl_area [MaxClusters];
  logic [SumW-1:0]  mdl_sx   [MaxClusters];
  logic [SumW-1:0]  mdl_sy   [MaxClusters];
  logic [SumW-1:0]  mdl_sz   [MaxClusters];
  logic [CntW-1:0]  mdl_count;

  verdict_t    verdict_q [$];
  dir_row_t    dir_tab [$];
  int unsigned n_err = 0;
  int unsigned n_faces = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  logic [CntW-1:0] eff_count;

  always #4 clk_i = ~clk_i;

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic got, input logic exp);
    $display("mismatch %s: got %0b expected %0b at cycle %0d", what, got, exp, cycles);
    n_err++;
  endtask

  function automatic logic [SumW-1:0] mag(input logic [SumW-1:0] v);
    return v[SumW-1] ? -v : v;
  endfunction

  // |W|^2 / A with truncation; A nonzero
  function automatic logic [127:0] energy_term(input logic [SumW-1:0] x,
      input logic [SumW-1:0] y, input logic [SumW-1:0] z, input logic [AreaW-1:0] a);
    logic [127:0] mx, my, mz, s;
    mx = 128'(mag(x));
    my = 128'(mag(y));
    mz = 128'(mag(z));
    s = mx * mx + my * my + mz * mz;
    return s / 128'(a);
  endfunction

  // Decide one face and update the model store
  function automatic verdict_t judge_face(input face_t f);
    verdict_t v;
    logic [8:0] lim;
    logic free_src, bad;
    logic [SumW-1:0] cx, cy, cz, tx, ty, tz, ox, oy, oz;
    logic [AreaW-1:0] ao, an, ao1, an1;
    logic [127:0] e_old, e_new;
    int s, t;
    lim = (mdl_count > 9'(MaxClusters)) ? 9'(MaxClusters) : mdl_count;
    free_src = (f.src == FreeSrc);
    bad = (9'(f.tgt) >= lim) || (!free_src && 9'(f.src) >= lim);
    v.acc = 1'b0;
    v.bad = bad;
    if (bad) return v;
    cx = {{(SumW-CoordW){f.wx[CoordW-1]}}, f.wx};
    cy = {{(SumW-CoordW){f.wy[CoordW-1]}}, f.wy};
    cz = {{(SumW-CoordW){f.wz[CoordW-1]}}, f.wz};
    t = int'(f.tgt);
    if (free_src) begin
      mdl_area[t] = mdl_area[t] + AreaW'(f.area);
      mdl_sx[t] = mdl_sx[t] + cx;
      mdl_sy[t] = mdl_sy[t] + cy;
      mdl_sz[t] = mdl_sz[t] + cz;
      v.acc = 1'b1;
      return v;
    end
    s = int'(f.src[7:0]);
    ao = mdl_area[s];
    an = mdl_area[t];
    if (ao <= AreaW'(f.area) || an == '0) return v;
    ao1 = ao - AreaW'(f.area);
    an1 = an + AreaW'(f.area);
    if (an1 == '0) return v;
    tx = mdl_sx[t] + cx;
    ty = mdl_sy[t] + cy;
    tz = mdl_sz[t] + cz;
    ox = mdl_sx[s] - cx;
    oy = mdl_sy[s] - cy;
    oz = mdl_sz[s] - cz;
    e_old = energy_term(mdl_sx[s], mdl_sy[s], mdl_sz[s], ao)
          + energy_term(mdl_sx[t], mdl_sy[t], mdl_sz[t], an);
    e_new = energy_term(ox, oy, oz, ao1) + energy_term(tx, ty, tz, an1);
    if (!(e_new > e_old)) return v;
    // Target first, then source, so a same-cluster move cancels out
    mdl_area[t] = an1;
    mdl_sx[t] = tx;
    mdl_sy[t] = ty;
    mdl_sz[t] = tz;
    mdl_area[s] = mdl_area[s] - AreaW'(f.area);
    mdl_sx[s] = mdl_sx[s] - cx;
    mdl_sy[s] = mdl_sy[s] - cy;
    mdl_sz[s] = mdl_sz[s] - cz;
    v.acc = 1'b1;
    return v;
  endfunction

  // Offer one face, hold it until taken, then maybe open a gap
  task automatic send_face(input face_t f, input logic known, input verdict_t want);
    verdict_t v;
    in_if.valid          <= 1'b1;
    in_if.source_cluster <= f.src;
    in_if.target_cluster <= f.tgt;
    in_if.face_area      <= f.area;
    in_if.weighted_x     <= f.wx;
    in_if.weighted_y     <= f.wy;
    in_if.weighted_z     <= f.wz;
    do @(posedge clk_i); while (!in_if.ready);
    v = judge_face(f);
    if (known && v != want) begin
      report("table vs model", v.acc, want.acc);
    end
    verdict_q.push_back(v);
    n_faces++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait for every outstanding decision
  task automatic drain;
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CntW-1:0] c);
    drain();
    cfg_if.valid         <= 1'b1;
    cfg_if.cluster_count <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mdl_count = c;
    @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] rand_coord;
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return CoordW'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic face_t rand_face(input int span, input int pct_free);
    face_t f;
    int r;
    r = $urandom_range(0, 99);
    f.tgt = TgtW'($urandom_range(0, span));
    if ($urandom_range(0, 49) == 0) f.tgt = TgtW'($urandom);
    if (r < pct_free) begin
      f.src = FreeSrc;
    end else if (r < pct_free + 4) begin
      f.src = SrcW'($urandom);
    end else begin
      f.src = SrcW'($urandom_range(0, span));
    end
    case ($urandom_range(0, 9))
      0:       f.area = FaceW'($urandom);
      1:       f.area = '1;
      2:       f.area = '0;
      default: f.area = FaceW'($urandom_range(1, 300));
    endcase
    f.wx = rand_coord();
    f.wy = rand_coord();
    f.wz = rand_coord();
    return f;
  endfunction

  // Random phase: load a few clusters, then mostly moves between them
  task automatic random_phase(input int n, input int span);
    face_t f;
    for (int i = 0; i < n; i++) begin
      f = (i < span * 3) ? rand_face(span, 100) : rand_face(span, 20);
      send_face(f, 1'b0, '0);
    end
  endtask

  task automatic add_row(input logic [SrcW-1:0] src, input logic [TgtW-1:0] tgt,
      input logic [FaceW-1:0] area, input logic [CoordW-1:0] wx,
      input logic [CoordW-1:0] wy, input logic [CoordW-1:0] wz,
      input logic known, input logic acc, input logic bad);
    dir_row_t r;
    r.face = '{src: src, tgt: tgt, area: area, wx: wx, wy: wy, wz: wz};
    r.known = known;
    r.want = '{acc: acc, bad: bad};
    dir_tab.push_back(r);
  endtask

  // Compare each decision with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        report("unexpected transaction", out_if.accepted, 1'b0);
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_if.accepted !== exp_v.acc) report("accepted", out_if.accepted, exp_v.acc);
        if (out_if.bad_cluster !== exp_v.bad) begin
          report("bad_cluster", out_if.bad_cluster, exp_v.bad);
        end
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off mid-run
  initial begin
    int unsigned hold;
    bit held;
    held = 1'b0;
    hold = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_faces >= 300) begin
        held = 1'b1;
        hold = 3000;
      end
      if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if ((cycles / 500) % 3 == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Main sequence
  initial begin
    in_if.valid          <= 1'b0;
    in_if.source_cluster <= '0;
    in_if.target_cluster <= '0;
    in_if.face_area      <= '0;
    in_if.weighted_x     <= '0;
    in_if.weighted_y     <= '0;
    in_if.weighted_z     <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.cluster_count <= '0;
    for (int i = 0; i < MaxClusters; i++) begin
      mdl_area[i] = '0;
      mdl_sx[i] = '0;
      mdl_sy[i] = '0;
      mdl_sz[i] = '0;
    end
    mdl_count = CntReset;

    // Directed table, count at reset value
    add_row(9'd0, 8'd1, 24'd1, 32'd5, 32'd5, 32'd5, 1'b1, 1'b0, 1'b0);   // source empty
    add_row(FreeSrc, 8'd0, '1, 32'h7FFF_FFFF, 32'h8000_0000, '1, 1'b1, 1'b1, 1'b0);
    add_row(FreeSrc, 8'd255, '0, '0, '0, '0, 1'b1, 1'b1, 1'b0);
    add_row(9'h1FE, 8'd0, 24'd3, '0, '0, '0, 1'b1, 1'b0, 1'b1);   // other negative
    add_row(9'h100, 8'd0, 24'd3, '0, '0, '0, 1'b1, 1'b0, 1'b1);   // most negative
    add_row(9'd0, 8'd1, 24'd1, 32'd7, '0, '0, 1'b1, 1'b0, 1'b0);  // empty target
    add_row(FreeSrc, 8'd1, 24'd5, 32'd100, 32'h8000_0000, 32'd3, 1'b1, 1'b1, 1'b0);
    add_row(9'd0, 8'd1, 24'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    add_row(9'd0, 8'd0, 24'd1, 32'd9, 32'd9, 32'd9, 1'b0, 1'b0, 1'b0);   // same cluster
    add_row(9'd1, 8'd0, 24'hFFFFFF, '0, '0, '0, 1'b1, 1'b0, 1'b0); // would empty source
    add_row(9'd255, 8'd0, '0, '0, '0, '0, 1'b1, 1'b0, 1'b0);      // zero-area source
    add_row(FreeSrc, 8'd2, 24'd10, 32'd1000, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);
    add_row(FreeSrc, 8'd3, 24'd10, -32'd1000, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);
    add_row(9'd2, 8'd3, 24'd1, 32'd100, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(9'd3, 8'd2, 24'd1, -32'd100, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(9'd1, 8'd2, 24'd2, 32'd40, 32'h8000_0000, 32'd1, 1'b0, 1'b0, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_face(dir_tab[i].face, dir_tab[i].known, dir_tab[i].want);

    // Zero count: everything is out of range
    write_count(9'd0);
    send_face('{src: FreeSrc, tgt: 8'd0, area: 24'd1, wx: '0, wy: '0, wz: '0}, 1'b1,
              '{1'b0, 1'b1});
    send_face('{src: 9'd0, tgt: 8'd0, area: 24'd1, wx: '0, wy: '0, wz: '0}, 1'b1,
              '{1'b0, 1'b1});

    // Single cluster, then upper boundary and beyond
    write_count(9'd1);
    send_face('{src: FreeSrc, tgt: 8'd1, area: 24'd1, wx: '0, wy: '0, wz: '0}, 1'b1,
              '{1'b0, 1'b1});
    random_phase(60, 1);
    write_count(9'd511);
    random_phase(500, 7);
    write_count(9'd255);
    send_face('{src: FreeSrc, tgt: 8'd255, area: 24'd1, wx: '0, wy: '0, wz: '0}, 1'b1,
              '{1'b0, 1'b1});
    random_phase(400, 5);
    write_count(9'd5);
    random_phase(500, 6);

    // Sender pause until idle, then finish with the reset count
    write_count(9'd256);
    random_phase(540, 3);

    drain();
    repeat (600) @(posedge clk_i);
    if (verdict_q.size() == 0 && n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
